/* hw/rtl/rgbfade_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB fade stepper package
// Transfer types, command codes and fixed constants shared by the fade
// stepper and its checker.
// ----------------------------------------------------------------------------
package rgbfade_pkg;

  // Command codes carried in the input transfer.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Reset value of the step interval register.
  localparam logic [15:0] STEP_INTERVAL_RESET = 16'd1000;

  // The multiply and divide each retire one bit per cycle, eight bits each.
  localparam logic [2:0] DIGIT_LAST = 3'd7;

  typedef struct packed {
    logic        command;
    logic [23:0] start_color;
    logic [23:0] end_color;
  } fade_in_t;

  typedef struct packed {
    logic [23:0] color;
    logic [7:0]  step_number;
    logic        last;
  } fade_out_t;

endpackage

/* hw/rtl/rgb_linear_fade_stepper_top.sv */
`timescale 1ns / 1ps
// A start transfer's result passes through the result register and then
// the output register. For a tick that ends an interval the input stalls
// while eight multiply bits and eight divide bits run and the step waits
// for the output register. A tick that ends no interval does not stall it.
// Reset (rst_ni low, asynchronous) leaves the block idle with no fade
// running, the output empty and the step interval at 1000.
// ----------------------------------------------------------------------------
// RGB linear fade stepper
// Steps a color from a start color toward an end color along a straight line
// in integer steps, one step after every step interval worth of ticks.
// ----------------------------------------------------------------------------
module rgb_linear_fade_stepper_top import rgbfade_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  // Command channel: starts and ticks.
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fade_in_t  in_data_i,
  // Step results.
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fade_out_t out_data_o,
  // Step interval register write.
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // The sequencer walks through a serial multiply and a serial divide that
  // work on all three channels side by side. The result then waits in PEND
  // until the output register is free.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_PEND = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] interval_q, interval_d;
  logic        out_valid_q, out_valid_d;

  // Fade parameters, kept from the start transfer.
  logic [23:0] base_q, base_d;
  logic [8:0]  delta_q [3];
  logic [8:0]  delta_d [3];
  logic [7:0]  total_q, total_d;
  logic [7:0]  next_q, next_d;

  // Step engine. The accumulator first builds |delta| * i most significant
  // bit first; the divide then treats its upper byte as the partial
  // remainder and shifts quotient bits into its lower byte.
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  mplr_q, mplr_d;
  logic [15:0] acc_q [3];
  logic [15:0] acc_d [3];

  fade_out_t   res_q, res_d;
  fade_out_t   out_q, out_d;

  // Per-channel arithmetic.
  logic [8:0]  st_diff  [3];
  logic [7:0]  st_abs   [3];
  logic [7:0]  st_max;
  logic [7:0]  dmag     [3];
  logic [15:0] mul_nxt  [3];
  logic [8:0]  div_trial[3];
  logic [15:0] div_nxt  [3];
  logic [7:0]  step_ch  [3];

  logic [15:0] tick_inc;
  logic [15:0] limit;
  logic        step_fin;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  // The interval register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  assign tick_inc = tick_q + 16'd1;
  // An interval of zero behaves as an interval of one.
  assign limit    = (interval_q == 16'd0) ? 16'd1 : interval_q;
  // The step being finished is the final one when i + 1 reaches N.
  assign step_fin = (({1'b0, idx_q} + 9'd1) >= {1'b0, total_q});

  // Channel 0 is red (bits 23:16), channel 2 is blue (bits 7:0).
  always_comb begin : chan_math
    for (int c = 0; c < 3; c++) begin
      st_diff[c]   = {1'b0, in_data_i.end_color[(2-c)*8 +: 8]}
                   - {1'b0, in_data_i.start_color[(2-c)*8 +: 8]};
      st_abs[c]    = st_diff[c][8] ? 8'(-st_diff[c]) : st_diff[c][7:0];
      dmag[c]      = delta_q[c][8] ? 8'(-delta_q[c]) : delta_q[c][7:0];
      mul_nxt[c]   = {acc_q[c][14:0], 1'b0} + (mplr_q[7] ? {8'd0, dmag[c]} : 16'd0);
      // The product is below N * 256, so the remainder always fits a byte.
      div_trial[c] = {acc_q[c][15:8], acc_q[c][7]};
      if (div_trial[c] >= {1'b0, total_q}) begin
        div_nxt[c] = {8'(div_trial[c] - {1'b0, total_q}), acc_q[c][6:0], 1'b1};
      end else begin
        div_nxt[c] = {div_trial[c][7:0], acc_q[c][6:0], 1'b0};
      end
      // Apply the sign of the delta to the quotient, which truncates toward zero.
      if (delta_q[c][8]) begin
        step_ch[c] = base_q[(2-c)*8 +: 8] - div_nxt[c][7:0];
      end else begin
        step_ch[c] = base_q[(2-c)*8 +: 8] + div_nxt[c][7:0];
      end
    end
  end

  always_comb begin : step_count
    st_max = st_abs[0];
    if (st_abs[1] > st_max) begin
      st_max = st_abs[1];
    end
    if (st_abs[2] > st_max) begin
      st_max = st_abs[2];
    end
  end

  always_comb begin : control
    state_d    = state_q;
    cnt_d      = cnt_q;
    busy_d     = busy_q;
    tick_d     = tick_q;
    interval_d = interval_q;
    base_d     = base_q;
    total_d    = total_q;
    next_d     = next_q;
    idx_d      = idx_q;
    mplr_d     = mplr_q;
    res_d      = res_q;
    out_d      = out_q;
    for (int c = 0; c < 3; c++) begin
      delta_d[c] = delta_q[c];
      acc_d[c]   = acc_q[c];
    end
    // A waiting result leaves the output register once it is taken.
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.command == CMD_START) begin
            // A start always replaces whatever fade was running.
            base_d  = in_data_i.start_color;
            total_d = st_max;
            next_d  = 8'd0;
            tick_d  = 16'd0;
            for (int c = 0; c < 3; c++) begin
              delta_d[c] = st_diff[c];
            end
            res_d.step_number = 8'd0;
            if (st_max == 8'd0) begin
              // Equal colors: the end color goes out at once as the last step.
              busy_d      = 1'b0;
              res_d.color = in_data_i.end_color;
              res_d.last  = 1'b1;
            end else begin
              res_d.color = in_data_i.start_color;
              res_d.last  = (st_max == 8'd1);
              busy_d      = (st_max != 8'd1);
              if (st_max != 8'd1) begin
                next_d = 8'd1;
              end
            end
            state_d = ST_PEND;
          end else if (busy_q) begin
            if (tick_inc < limit) begin
              tick_d = tick_inc;
            end else begin
              // The interval has run out: compute the next step.
              tick_d = 16'd0;
              idx_d  = next_q;
              mplr_d = next_q;
              cnt_d  = 3'd0;
              for (int c = 0; c < 3; c++) begin
                acc_d[c] = 16'd0;
              end
              state_d = ST_MUL;
            end
          end
        end
      end

      ST_MUL: begin
        for (int c = 0; c < 3; c++) begin
          acc_d[c] = mul_nxt[c];
        end
        mplr_d = {mplr_q[6:0], 1'b0};
        cnt_d  = cnt_q + 3'd1;
        if (cnt_q == DIGIT_LAST) begin
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        for (int c = 0; c < 3; c++) begin
          acc_d[c] = div_nxt[c];
        end
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == DIGIT_LAST) begin
          res_d.color       = {step_ch[0], step_ch[1], step_ch[2]};
          res_d.step_number = idx_q;
          res_d.last        = step_fin;
          if (step_fin) begin
            busy_d = 1'b0;
          end else begin
            next_d = idx_q + 8'd1;
          end
          state_d = ST_PEND;
        end
      end

      ST_PEND: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      interval_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 3'd0;
      busy_q      <= 1'b0;
      tick_q      <= 16'd0;
      interval_q  <= STEP_INTERVAL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      tick_q      <= tick_d;
      interval_q  <= interval_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers carry no reset; they are loaded before they are used.
  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    total_q <= total_d;
    next_q  <= next_d;
    idx_q   <= idx_d;
    mplr_q  <= mplr_d;
    res_q   <= res_d;
    out_q   <= out_d;
    for (int c = 0; c < 3; c++) begin
      delta_q[c] <= delta_d[c];
      acc_q[c]   <= acc_d[c];
    end
  end

endmodule

/* hw/rtl/rgbfade_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB fade stepper checker
// Port-level assertions on the fade stepper, bound to its top level.
// ----------------------------------------------------------------------------
module rgbfade_checker import rgbfade_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input fade_in_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input fade_out_t   out_data_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // Once reset has been seen at an edge there is no result and commands are
  // not blocked.
  assert property (@(posedge clk_i) !rst_ni |=> (!out_valid_o && !in_stall_o))
    else $error("fade stepper not quiet in reset");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // A start transfer with an empty output shows step 0 on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.command == CMD_START) && !out_valid_o)
      |-> ##2 (out_valid_o && (out_data_o.step_number == 8'd0)))
    else $error("start did not produce step 0");

  // Equal colors finish at once with the end color as the last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.command == CMD_START) && !out_valid_o &&
     (in_data_i.start_color == in_data_i.end_color))
      |-> ##2 (out_valid_o && out_data_o.last &&
               (out_data_o.color == $past(in_data_i.end_color, 2))))
    else $error("equal-color fade wrong");

  // The interval register accepts a transfer in every cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("interval write refused");

endmodule

bind rgb_linear_fade_stepper_top rgbfade_checker u_checker (.*);

/* tb/rgb_fade_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB fade stepper checker
// Watches the command, step and interval channels of the fade stepper,
// predicts every fade step from the accepted commands and compares each
// step transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_fade_checker import rgbfade_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  fade_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  fade_out_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Shadow of the fade state. Channel 0 is blue, 1 green, 2 red.
  logic [15:0]       interval_q;
  logic [23:0]       base_q;
  logic signed [8:0] delta_q [3];
  logic [7:0]        steps_q;
  logic [7:0]        next_q;
  logic [15:0]       ticks_q;
  logic              busy_q;
  fade_out_t         expected_steps [$];

  function automatic logic [7:0] channel_at(input logic [7:0] origin,
                                            input logic signed [8:0] delta,
                                            input int idx, input int total);
    int offset;
    // Integer division truncates toward zero, as the fade requires.
    offset = (int'(delta) * idx) / total;
    return 8'(int'(origin) + offset);
  endfunction

  task automatic queue_step(input int idx);
    fade_out_t step;
    int        ch;
    for (ch = 0; ch < 3; ch++) begin
      step.color[ch*8 +: 8] = channel_at(base_q[ch*8 +: 8], delta_q[ch], idx, steps_q);
    end
    step.step_number = 8'(idx);
    step.last        = (idx + 1 >= int'(steps_q));
    expected_steps.push_back(step);
    if (step.last) begin
      busy_q = 1'b0;
    end else begin
      next_q = 8'(idx + 1);
    end
  endtask

  task automatic predict_command(input fade_in_t cmd);
    int        diff;
    int        mag;
    int        span;
    int        ch;
    fade_out_t step;
    if (cmd.command == CMD_START) begin
      span = 0;
      for (ch = 0; ch < 3; ch++) begin
        diff = int'(cmd.end_color[ch*8 +: 8]) - int'(cmd.start_color[ch*8 +: 8]);
        delta_q[ch] = 9'(diff);
        mag = (diff < 0) ? -diff : diff;
        if (mag > span) span = mag;
      end
      base_q  = cmd.start_color;
      steps_q = 8'(span);
      next_q  = 8'd0;
      ticks_q = 16'd0;
      if (span == 0) begin
        // Equal colors finish at once on the end color.
        busy_q           = 1'b0;
        step.color       = cmd.end_color;
        step.step_number = 8'd0;
        step.last        = 1'b1;
        expected_steps.push_back(step);
      end else begin
        busy_q = 1'b1;
        queue_step(0);
      end
    end else if (busy_q) begin
      ticks_q = ticks_q + 16'd1;
      if (ticks_q >= ((interval_q == 16'd0) ? 16'd1 : interval_q)) begin
        ticks_q = 16'd0;
        queue_step(next_q);
      end
    end
  endtask

  task automatic check_step(input fade_out_t got);
    fade_out_t want;
    bit        bad;
    if (expected_steps.size() == 0) begin
      $display("%0t: unexpected step transfer: expected none, actual color %h step %0d last %b",
               $time, got.color, got.step_number, got.last);
      fail_count_o++;
      return;
    end
    want = expected_steps.pop_front();
    bad  = 1'b0;
    if (got.color !== want.color) begin
      bad = 1'b1;
      $display("%0t: color mismatch: expected %h, actual %h",
               $time, want.color, got.color);
    end
    if (got.step_number !== want.step_number) begin
      bad = 1'b1;
      $display("%0t: step number mismatch: expected %0d, actual %0d",
               $time, want.step_number, got.step_number);
    end
    if (got.last !== want.last) begin
      bad = 1'b1;
      $display("%0t: last flag mismatch: expected %b, actual %b",
               $time, want.last, got.last);
    end
    if (bad) fail_count_o++;
  endtask

  // The step output is checked before the command of the same edge is
  // predicted, so a step can never be matched against its own command.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q = STEP_INTERVAL_RESET;
      base_q     = '0;
      delta_q[0] = '0;
      delta_q[1] = '0;
      delta_q[2] = '0;
      steps_q    = '0;
      next_q     = '0;
      ticks_q    = '0;
      busy_q     = 1'b0;
      expected_steps.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_step(out_data_i);
      if (in_valid_i && !in_stall_i) predict_command(in_data_i);
      if (cfg_valid_i && cfg_ready_i) interval_q = cfg_data_i;
    end
    pending_o = expected_steps.size();
  end

endmodule

/* tb/tb_rgb_linear_fade_stepper_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB fade stepper testbench
// Drives start and tick commands into the fade stepper, with bursty input
// traffic and a receiver that stalls on its own pattern. The interval
// register is rewritten between phases, including its extremes. A checker
// beside the block predicts every step and counts mismatches; this module
// only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_rgb_linear_fade_stepper_top;
  import rgbfade_pkg::*;

  // A correct run never goes this long without some transfer. The worst
  // honest stretch is a receiver hold, the block's compute stall, a sender
  // gap and the drain before an interval write, well under this.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles allowed after the last expected step before an interval write or
  // the verdict.
  localparam int DRAIN_CYCLES   = 24;

  typedef enum int {RX_FREE, RX_JITTER, RX_HOLD} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  fade_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  fade_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  // Sender burst shaping: burst_left transfers remain in the current burst,
  // and a gap of up to gap_max idle cycles may come before the next one.
  int          burst_left = 0;
  int          gap_max = 12;
  int          cur_interval = int'(STEP_INTERVAL_RESET);

  int          idle_cycles = 0;
  rx_mode_e    rx_mode = RX_FREE;
  int          rx_run = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_linear_fade_stepper_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  rgb_fade_checker u_fade_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The receiver switches between free running, random single-cycle stalls
  // and solid holds, each for a run of random length. Long free runs give
  // stretches with no back pressure at all.
  always @(negedge clk) begin
    if (rx_run == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_run  = (rx_mode == RX_HOLD) ? $urandom_range(1, 24) : $urandom_range(1, 60);
    end
    rx_run--;
    case (rx_mode)
      RX_FREE: begin
        out_stall <= 1'b0;
      end
      RX_JITTER: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= 1'b1;
      end
    endcase
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d steps outstanding", $time, pending);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Sends one command and returns at the falling edge after its transfer.
  // Within a burst valid simply stays high while the payload moves on, so
  // back-to-back transfers need no extra edge.
  task automatic send_command(input logic cmd, input logic [23:0] from_color,
                              input logic [23:0] to_color);
    fade_in_t item;
    int       gap;
    item.command     = cmd;
    item.start_color = from_color;
    item.end_color   = to_color;
    if (burst_left == 0) begin
      gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  // Tick transfers carry random color fields, which the block must ignore.
  task automatic send_ticks(input int count);
    repeat (count) send_command(CMD_TICK, 24'($urandom()), 24'($urandom()));
  endtask

  // Lets every predicted step arrive, then waits out any tick still in
  // flight that will produce nothing, so the block is idle afterwards.
  task automatic quiesce();
    in_valid   <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_interval(input logic [15:0] value);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid    <= 1'b0;
    cur_interval = int'(value);
  endtask

  // Channels lean toward the extremes so that full-scale differences of
  // both signs turn up often.
  function automatic logic [23:0] pick_color();
    logic [23:0] color;
    int          ch;
    for (ch = 0; ch < 3; ch++) begin
      case ($urandom_range(0, 3))
        0:       color[ch*8 +: 8] = 8'h00;
        1:       color[ch*8 +: 8] = 8'hFF;
        default: color[ch*8 +: 8] = 8'($urandom());
      endcase
    end
    return color;
  endfunction

  // A color within spread of origin on every channel, clamped to the
  // channel range, so the fade has at most spread steps.
  function automatic logic [23:0] near_color(input logic [23:0] origin, input int spread);
    logic [23:0] color;
    int          ch;
    int          level;
    for (ch = 0; ch < 3; ch++) begin
      level = int'(origin[ch*8 +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      color[ch*8 +: 8] = 8'(level);
    end
    return color;
  endfunction

  // Mostly short fades driven to their end with the right number of ticks,
  // some cut short by the next start, plus wide fades that are given a random
  // number of ticks, and a share of loose random commands.
  task automatic random_phase(input int item_goal);
    int          sent;
    int          spread;
    int          tick_total;
    int          ticks_per_step;
    logic [23:0] from_color;
    sent           = 0;
    ticks_per_step = (cur_interval == 0) ? 1 : cur_interval;
    while (sent < item_goal) begin
      from_color = pick_color();
      case ($urandom_range(0, 9))
        0, 1: begin
          send_command($urandom_range(0, 1) ? CMD_TICK : CMD_START, from_color, pick_color());
          tick_total = 0;
        end
        2, 3: begin
          send_command(CMD_START, from_color, pick_color());
          tick_total = $urandom_range(0, 3 * ticks_per_step + 4);
        end
        default: begin
          spread = $urandom_range(0, 6);
          send_command(CMD_START, from_color, near_color(from_color, spread));
          if ($urandom_range(0, 4) == 0) begin
            tick_total = $urandom_range(0, ticks_per_step * spread);
          end else begin
            tick_total = ticks_per_step * spread + $urandom_range(0, 2);
          end
        end
      endcase
      send_ticks(tick_total);
      sent += 1 + tick_total;
    end
  endtask

  initial begin
    int phase_intervals [8];
    phase_intervals = '{1, 2, 0, 3, 1, 5, 2, 4};

    // Reset is held low from the start and released on a falling edge.
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part, first with the interval still at its reset value.
    // A tick with no fade running must produce nothing.
    send_ticks(1);
    // Equal colors finish at once on the end color.
    send_command(CMD_START, 24'h123456, 24'h123456);
    // A difference of one gives a single step that is also the last.
    send_command(CMD_START, 24'h000000, 24'h000001);
    send_command(CMD_START, 24'h7F7F7F, 24'h7E7F7F);
    // Full-scale fall on every channel; the reset interval is long, so a
    // few dozen ticks must produce nothing beyond step 0.
    send_command(CMD_START, 24'hFFFFFF, 24'h000000);
    send_ticks(40);
    // A start while busy drops the running fade and clears the tick count.
    send_command(CMD_START, 24'h000000, 24'hFFFFFF);
    send_ticks(20);
    send_command(CMD_START, 24'h00FF80, 24'hFF0080);

    // With one tick per step the mixed-sign fade runs to its last step,
    // number 254; the surplus ticks find the block idle.
    write_interval(16'd1);
    send_ticks(260);

    // An interval of zero behaves as one.
    write_interval(16'd0);
    send_command(CMD_START, 24'h102030, 24'h132030);
    send_ticks(4);

    // Largest interval: a run of ticks far short of it produces nothing.
    // The sender runs without gaps here.
    write_interval(16'hFFFF);
    gap_max = 0;
    send_command(CMD_START, 24'h000000, 24'h000002);
    send_ticks(30);
    gap_max = 12;

    // Random part, one phase per interval setting.
    foreach (phase_intervals[p]) begin
      write_interval(16'(phase_intervals[p]));
      random_phase(130);
    end

    quiesce();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
